/* hdl/binary_trie_xor_max_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the binary trie block
// Each macro expands to one labelled concurrent assertion on clk, held off
// while rst is high.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_XOR_MAX_ASSERT_SVH
`define BINARY_TRIE_XOR_MAX_ASSERT_SVH

// Condition implies consequence in the same cycle
`define BTXM_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define BTXM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/btxm_pkg.sv */
// ----------------------------------------------------------------------------
// btxm_pkg
// Sizes, codes, path record type and link row helpers for the binary trie.
// ----------------------------------------------------------------------------
`default_nettype none

package btxm_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODES      = 4096;
  localparam int CNT_W      = 16;
  localparam int VAL_W      = 31;
  localparam int NODE_W     = $clog2(NODES);
  localparam int USED_W     = $clog2(NODES + 1);
  localparam int STEP_W     = $clog2(KEY_BITS + 1);
  localparam int KIDX_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int IN_DATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_BITS   = VAL_W + CNT_W + USED_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_COUNT  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_POOL_FULL = 2'd1,
    RES_NOT_FOUND = 2'd2,
    RES_EMPTY     = 2'd3
  } status_t;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [2*NODE_W-1:0] row_t;

  // One level of a walked path: node id, its child links and pass count
  typedef struct packed {
    node_t            node;
    row_t             row;
    logic [CNT_W-1:0] pass;
  } path_rec_t;

  function automatic node_t link_of(row_t r, logic b);
    return b ? r[2*NODE_W-1:NODE_W] : r[NODE_W-1:0];
  endfunction

  function automatic row_t set_link(row_t r, logic b, node_t v);
    row_t o;
    o = r;
    if (b) o[2*NODE_W-1:NODE_W] = v;
    else   o[NODE_W-1:0]        = v;
    return o;
  endfunction

endpackage

`default_nettype wire

/* hdl/btxm_cell.sv */
// ----------------------------------------------------------------------------
// btxm_cell
// One path cell: holds the record of one trie level and takes its
// neighbour's record on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module btxm_cell (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire btxm_pkg::path_rec_t d,
  output btxm_pkg::path_rec_t     q
);

  // Take the neighbour's record
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

/* hdl/btxm_chain.sv */
// ----------------------------------------------------------------------------
// btxm_chain
// Row of path cells, one per key level. Records enter at the tail while the
// trie is walked and leave at the head, top level first, while it is updated.
// ----------------------------------------------------------------------------
`default_nettype none

module btxm_chain (
  input  wire logic                clk,
  input  wire logic                shift,
  input  wire btxm_pkg::path_rec_t tail_in,
  output btxm_pkg::path_rec_t      head,
  output btxm_pkg::path_rec_t      head_next
);

  btxm_pkg::path_rec_t q [btxm_pkg::KEY_BITS];

  // Each cell hands its record one place towards the head
  for (genvar i = 0; i < btxm_pkg::KEY_BITS; i++) begin : g_cell
    if (i == btxm_pkg::KEY_BITS - 1) begin : g_tail
      btxm_cell u_cell (.clk(clk), .shift(shift), .d(tail_in), .q(q[i]));
    end else begin : g_mid
      btxm_cell u_cell (.clk(clk), .shift(shift), .d(q[i+1]), .q(q[i]));
    end
  end

  assign head      = q[0];
  assign head_next = q[1];

endmodule

`default_nettype wire

/* hdl/binary_trie_xor_max.sv */
// ----------------------------------------------------------------------------
// binary_trie_xor_max
// Binary trie with insert, erase, copy count and max-XOR query over 31-bit
// keys, walked most significant bit first.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser is the operation (insert, erase, count,
//   query), tdata the key. m_axis returns one result per request: tuser is
//   the status, tdata the value, key total and nodes in use.
//   A request is walked down the trie one level a cycle through the link,
//   pass and end memories (one registered read port each); every level is
//   recorded in a chain of path cells. Insert and erase then replay the
//   chain, one level a cycle, writing the memories.
//   s_axis_tready is high only between requests. A finished result sits in
//   the output register; while m_axis_tready is low the next request may
//   still be taken and walked, and it waits at its own result until the
//   register is free.
//   Reset empties the trie at once (root links cleared, one node in use,
//   key total zero); node memories need no clearing since every node is
//   written when it is allocated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_trie_xor_max_assert.svh"

module binary_trie_xor_max (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // key [30:0]
  input  wire logic [btxm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // kind [1:0]
  input  wire logic [1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // value [30:0], stored_keys [46:31], nodes_used [59:47]
  output logic [btxm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // status [1:0]
  output logic [1:0]                              m_axis_tuser
);

  localparam int KEY_BITS = btxm_pkg::KEY_BITS;
  localparam int NODES    = btxm_pkg::NODES;
  localparam int CNT_W    = btxm_pkg::CNT_W;
  localparam int VAL_W    = btxm_pkg::VAL_W;
  localparam int NODE_W   = btxm_pkg::NODE_W;
  localparam int USED_W   = btxm_pkg::USED_W;
  localparam int STEP_W   = btxm_pkg::STEP_W;
  localparam int KIDX_W   = btxm_pkg::KIDX_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t                    state;
  btxm_pkg::op_t             kind_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [STEP_W-1:0]         step;
  btxm_pkg::node_t           cur;
  logic [STEP_W-1:0]         missing;
  logic [KEY_BITS-1:0]       best;
  logic [CNT_W-1:0]          leaf_end;
  logic [VAL_W-1:0]          res_value;
  btxm_pkg::status_t         res_status;
  logic [CNT_W-1:0]          key_total;
  logic [USED_W-1:0]         next_free;
  btxm_pkg::row_t            root_row;
  btxm_pkg::node_t           par_node;
  btxm_pkg::row_t            par_row;
  logic                      cut;

  // Node memories
  btxm_pkg::row_t            link_mem [NODES];
  logic [CNT_W-1:0]          pass_mem [NODES];
  logic [CNT_W-1:0]          end_mem  [NODES];
  btxm_pkg::row_t            rd_row;
  logic [CNT_W-1:0]          rd_pass;
  logic [CNT_W-1:0]          rd_end;

  logic                      lw_en, pw_en, ew_en;
  btxm_pkg::node_t           lw_addr, pw_addr, ew_addr;
  btxm_pkg::row_t            lw_data;
  logic [CNT_W-1:0]          pw_data, ew_data;

  // Walk and update terms
  logic [KIDX_W-1:0]         lvl, lvl_dn;
  logic                      cur_bit, nxt_bit, walk_pick, cur_ok, upd_last;
  btxm_pkg::row_t            cur_row;
  btxm_pkg::node_t           child_same, child_alt, walk_next;
  btxm_pkg::node_t           new_id, new_id_p1, ins_leaf;
  logic [STEP_W-1:0]         miss_total;
  logic [USED_W-1:0]         free_nodes;
  logic [CNT_W-1:0]          pass_dec;
  logic                      chain_shift;
  btxm_pkg::path_rec_t       tail_rec, head, head_next;

  // Terms watched by the checks
  logic                      pool_ok, ins_last, ers_upd;

  assign s_axis_tready = (state == S_IDLE);

  // Path chain
  assign tail_rec    = '{node: cur, row: rd_row, pass: rd_pass};
  assign chain_shift = ((state == S_WALK) && (step != '0)) || (state == S_UPDATE);

  btxm_chain u_chain (
    .clk       (clk),
    .shift     (chain_shift),
    .tail_in   (tail_rec),
    .head      (head),
    .head_next (head_next)
  );

  // Child selection for the walk, and the write requests of the update pass
  always_comb begin
    lvl        = KIDX_W'(KEY_BITS - 1) - step[KIDX_W-1:0];
    lvl_dn     = lvl - KIDX_W'(1);
    cur_bit    = key_r[lvl];
    nxt_bit    = key_r[lvl_dn];
    cur_row    = (step == '0) ? root_row : rd_row;
    cur_ok     = (step == '0) || (cur != '0);
    child_same = cur_ok ? btxm_pkg::link_of(cur_row, cur_bit) : '0;
    child_alt  = cur_ok ? btxm_pkg::link_of(cur_row, ~cur_bit) : '0;
    if ((kind_r == btxm_pkg::OP_QUERY) && (child_alt != '0)) begin
      walk_next = child_alt;
      walk_pick = ~cur_bit;
    end else begin
      walk_next = child_same;
      walk_pick = cur_bit;
    end
    miss_total = missing + STEP_W'(cur == '0);
    free_nodes = USED_W'(NODES) - next_free;
    upd_last   = (step == STEP_W'(KEY_BITS - 1));
    new_id     = next_free[NODE_W-1:0];
    new_id_p1  = new_id + NODE_W'(1);
    ins_leaf   = (head.node != '0) ? head.node : new_id;
    pass_dec   = head.pass - CNT_W'(1);

    lw_en = 1'b0; lw_addr = '0; lw_data = '0;
    pw_en = 1'b0; pw_addr = '0; pw_data = '0;
    ew_en = 1'b0; ew_addr = '0; ew_data = '0;
    if (state == S_UPDATE) begin
      if (kind_r == btxm_pkg::OP_INSERT) begin
        if (head.node != '0) begin
          pw_en   = 1'b1;
          pw_addr = head.node;
          pw_data = head.pass + CNT_W'(1);
          // link an existing node to the first fresh one below it
          if (!upd_last && (head_next.node == '0)) begin
            lw_en   = 1'b1;
            lw_addr = head.node;
            lw_data = btxm_pkg::set_link(head.row, nxt_bit, new_id);
          end
          if (upd_last) begin
            ew_en   = 1'b1;
            ew_addr = head.node;
            ew_data = leaf_end + CNT_W'(1);
          end
        end else begin
          // allocate: fresh nodes below are taken in order
          pw_en   = 1'b1;
          pw_addr = new_id;
          pw_data = CNT_W'(1);
          lw_en   = 1'b1;
          lw_addr = new_id;
          lw_data = upd_last ? '0 : btxm_pkg::set_link('0, nxt_bit, new_id_p1);
          if (upd_last) begin
            ew_en   = 1'b1;
            ew_addr = new_id;
            ew_data = CNT_W'(1);
          end
        end
      end else if (!cut) begin
        pw_en   = 1'b1;
        pw_addr = head.node;
        pw_data = pass_dec;
        if (pass_dec == '0) begin
          // cut the branch at its parent; the root lives in registers
          if (step != '0) begin
            lw_en   = 1'b1;
            lw_addr = par_node;
            lw_data = btxm_pkg::set_link(par_row, cur_bit, '0);
          end
        end else if (upd_last) begin
          ew_en   = 1'b1;
          ew_addr = head.node;
          ew_data = leaf_end - CNT_W'(1);
        end
      end
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (lw_en) link_mem[lw_addr] <= lw_data;
    rd_row <= link_mem[walk_next];
  end

  always_ff @(posedge clk) begin
    if (pw_en) pass_mem[pw_addr] <= pw_data;
    rd_pass <= pass_mem[walk_next];
  end

  always_ff @(posedge clk) begin
    if (ew_en) end_mem[ew_addr] <= ew_data;
    rd_end <= end_mem[walk_next];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      key_total     <= '0;
      next_free     <= USED_W'(1);
      root_row      <= '0;
      step          <= '0;
      cut           <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            kind_r  <= btxm_pkg::op_t'(s_axis_tuser);
            key_r   <= s_axis_tdata[KEY_BITS-1:0];
            step    <= '0;
            missing <= '0;
            best    <= '0;
            cut     <= 1'b0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          cur <= walk_next;
          if ((step != '0) && (cur == '0)) missing <= missing + STEP_W'(1);
          if (step != STEP_W'(KEY_BITS)) begin
            if (walk_next != '0) best <= {best[KEY_BITS-2:0], walk_pick};
            step <= step + STEP_W'(1);
          end else begin
            // whole path read: decide the outcome
            leaf_end <= rd_end;
            step     <= '0;
            case (kind_r)
              btxm_pkg::OP_INSERT: begin
                res_value <= '0;
                if ((key_total >= btxm_pkg::COUNT_MAX) ||
                    (USED_W'(miss_total) > free_nodes)) begin
                  res_status <= btxm_pkg::RES_POOL_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= btxm_pkg::RES_OK;
                  state      <= S_UPDATE;
                end
              end
              btxm_pkg::OP_ERASE: begin
                res_value <= '0;
                if ((cur == '0) || (rd_end == '0)) begin
                  res_status <= btxm_pkg::RES_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= btxm_pkg::RES_OK;
                  state      <= S_UPDATE;
                end
              end
              btxm_pkg::OP_COUNT: begin
                res_status <= btxm_pkg::RES_OK;
                res_value  <= (cur != '0) ? VAL_W'(rd_end) : '0;
                state      <= S_DONE;
              end
              default: begin
                state <= S_DONE;
                if (key_total == '0) begin
                  res_status <= btxm_pkg::RES_EMPTY;
                  res_value  <= '0;
                end else begin
                  res_status <= btxm_pkg::RES_OK;
                  res_value  <= VAL_W'(best);
                end
              end
            endcase
          end
        end
        S_UPDATE: begin
          par_node <= head.node;
          par_row  <= head.row;
          if (kind_r == btxm_pkg::OP_INSERT) begin
            if (head.node == '0) begin
              next_free <= next_free + USED_W'(1);
              if (step == '0) root_row <= btxm_pkg::set_link(root_row, cur_bit, new_id);
            end
          end else if (!cut && (pass_dec == '0)) begin
            cut <= 1'b1;
            if (step == '0) root_row <= btxm_pkg::set_link(root_row, cur_bit, '0);
          end
          if (upd_last) begin
            if (kind_r == btxm_pkg::OP_INSERT) begin
              key_total <= key_total + CNT_W'(1);
              res_value <= VAL_W'(ins_leaf);
            end else begin
              key_total <= key_total - CNT_W'(1);
            end
            state <= S_DONE;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= btxm_pkg::OUT_DATA_W'({next_free, key_total, res_value});
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  assign pool_ok  = (next_free <= USED_W'(NODES)) && (next_free != '0);
  assign ins_last = (state == S_UPDATE) && (kind_r == btxm_pkg::OP_INSERT) && upd_last;
  assign ers_upd  = (state == S_UPDATE) && (kind_r == btxm_pkg::OP_ERASE);

  `BTXM_ASSERT_HOLDS(a_pool_bound, 1'b1, pool_ok, "node pool count out of range")
  `BTXM_ASSERT_HOLDS(a_erase_path, ers_upd && !cut, head.node != '0, "erase left its path")
  `BTXM_ASSERT_NEXT(a_ins_total, ins_last, key_total == $past(key_total) + CNT_W'(1), "no key added")

endmodule

`default_nettype wire
